// ===== sv/tcs_pkg.sv =====
// Package for the tone chunk sequencer: item codes, chunk kinds, the
// stored chunk layout and the result record. No dependencies.
package tcs_pkg;

  // Widths of the item and result fields
  localparam int unsigned SLOT_IN_W = 4;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CTYPE_W   = 2;

  // Default store depth
  localparam int unsigned CHUNK_SLOTS_DEF = 16;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

  // Chunk kinds; every other code ends playback
  localparam logic [CTYPE_W-1:0] CT_NORMAL = 2'd0;
  localparam logic [CTYPE_W-1:0] CT_STOP   = 2'd1;
  localparam logic [CTYPE_W-1:0] CT_REPEAT = 2'd2;

  // One stored chunk, 42 bits
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   dur;
    logic [CTYPE_W-1:0] ctype;
  } chunk_t;

  localparam int unsigned CHUNK_W = $bits(chunk_t);

  // Drive state reported for every transaction
  typedef struct packed {
    logic                 tone_on;
    logic [FREQ_W-1:0]    tone_freq;
    logic [LEVEL_W-1:0]   tone_level;
    logic [SLOT_IN_W-1:0] slot_now;
  } result_t;

endpackage

// ===== sv/tcs_if.sv =====
// Handshake channels of the tone chunk sequencer: item input and result
// output, each with valid, ready and the payload. Depends on tcs_pkg.
interface tcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcs_pkg::KIND_W-1:0]     kind;
  logic [tcs_pkg::SLOT_IN_W-1:0]  slot;
  logic [tcs_pkg::FREQ_W-1:0]     freq_hz;
  logic [tcs_pkg::LEVEL_W-1:0]    loudness;
  logic [tcs_pkg::DUR_W-1:0]      duration_ms;
  logic [tcs_pkg::CTYPE_W-1:0]    chunk_type;

  modport source (output valid, kind, slot, freq_hz, loudness, duration_ms, chunk_type,
                  input ready);
  modport sink (input valid, kind, slot, freq_hz, loudness, duration_ms, chunk_type,
                output ready);
endinterface

interface tcs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           tone_on;
  logic [tcs_pkg::FREQ_W-1:0]     tone_freq;
  logic [tcs_pkg::LEVEL_W-1:0]    tone_level;
  logic [tcs_pkg::SLOT_IN_W-1:0]  slot_now;

  modport source (output valid, tone_on, tone_freq, tone_level, slot_now, input ready);
  modport sink (input valid, tone_on, tone_freq, tone_level, slot_now, output ready);
endinterface

// ===== sv/tcs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcs_outq.sv =====
// Two-entry result queue: output register plus skid register, so a new
// transaction can finish while the previous result waits. Uses tcs_pkg, tcs_if.
module tcs_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tcs_pkg::result_t data_i,
  output logic             skid_busy_o,
  tcs_out_if.source        result_o
);
  import tcs_pkg::*;

  logic    out_v_q, out_v_d;
  logic    sk_v_q, sk_v_d;
  result_t out_q, out_d;
  result_t sk_q, sk_d;
  logic    pop;

  assign pop = out_v_q && result_o.ready;

  // Move results between the skid and the output register
  always_comb begin
    out_v_d = out_v_q;
    sk_v_d  = sk_v_q;
    out_d   = out_q;
    sk_d    = sk_q;
    if (pop) begin
      if (sk_v_q) begin
        out_d  = sk_q;
        sk_v_d = push_i;
        sk_d   = data_i;
      end else if (push_i) begin
        out_d = data_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q) begin
        out_d   = data_i;
        out_v_d = 1'b1;
      end else begin
        sk_d   = data_i;
        sk_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign skid_busy_o         = sk_v_q;
  assign result_o.valid      = out_v_q;
  assign result_o.tone_on    = out_q.tone_on;
  assign result_o.tone_freq  = out_q.tone_freq;
  assign result_o.tone_level = out_q.tone_level;
  assign result_o.slot_now   = out_q.slot_now;

  // A result only arrives while the skid is free
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !sk_v_q) else $error("result pushed into a full queue");

  // The skid holds data only behind a full output register
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q) else $error("skid valid with empty output register");

  // A stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !result_o.ready |=> out_v_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

// ===== sv/tone_chunk_sequencer.sv =====
// Top level of the tone chunk sequencer: chunk store RAM, playback control
// and result queue. Depends on tcs_pkg, tcs_if, tcs_ram and tcs_outq.
//
// Usage: items arrive on item_i (valid/ready); each one yields exactly one
// transaction on result_o with the drive state after the item: tone_on,
// tone_freq and tone_level (both 0 while silent) and slot_now.
// Kinds: write stores a chunk in a slot, start plays from a slot and marks
// it as the first chunk, stop silences, tick counts one millisecond down.
// Write, stop and a tick that loads no chunk finish in the cycle they are
// accepted, and their result is registered in the result queue. Start,
// and a tick whose chunk runs out into a next or first chunk, pass through
// the load state: the chunk RAM read is registered, and the control waits
// for it before taking the next item.
// Reset clears the playback state to silent at slot 0; the chunk store is
// not cleared, and a slot must be written before it is played.
// When the receiver stalls, one more result is held in a skid register;
// item_i then drops ready until the skid register empties.
module tone_chunk_sequencer #(
  parameter int unsigned CHUNK_SLOTS = tcs_pkg::CHUNK_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcs_in_if.sink    item_i,
  tcs_out_if.source result_o
);
  import tcs_pkg::*;

  localparam int unsigned SLOT_W = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;

  // Control states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic                 state_q, state_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    first_q, first_d;
  logic [SLOT_W-1:0]    ld_slot_q, ld_slot_d;
  logic [DUR_W-1:0]     ms_q, ms_d;
  logic                 snd_q, snd_d;
  logic [FREQ_W-1:0]    freq_q, freq_d;
  logic [LEVEL_W-1:0]   lvl_q, lvl_d;
  logic [CTYPE_W-1:0]   type_q, type_d;

  logic                 accept;
  logic                 in_ready;
  logic                 skid_busy;
  logic [SLOT_IN_W-1:0] slot_red;
  logic [SLOT_W-1:0]    slot_idx;
  logic [SLOT_W-1:0]    next_slot;
  logic                 we;
  logic                 load_req;
  logic [SLOT_W-1:0]    load_addr;
  logic                 done;
  chunk_t               wr_chunk;
  logic [CHUNK_W-1:0]   rd_bits;
  chunk_t               rd_chunk;
  result_t              res;

  assign in_ready     = (state_q == ST_IDLE) && !skid_busy;
  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;

  // Reduce the slot number modulo the store depth (for a depth of 2 or more)
  always_comb begin
    slot_red = item_i.slot;
    for (int i = 0; i < 8; i++) begin
      if (32'(slot_red) >= CHUNK_SLOTS) begin
        slot_red = slot_red - SLOT_IN_W'(CHUNK_SLOTS);
      end
    end
  end

  assign slot_idx  = SLOT_W'(slot_red);
  assign next_slot = (cur_q == SLOT_W'(CHUNK_SLOTS - 1)) ? '0 : cur_q + 1'b1;

  assign wr_chunk = '{freq:  item_i.freq_hz,
                      level: item_i.loudness,
                      dur:   item_i.duration_ms,
                      ctype: item_i.chunk_type};
  assign rd_chunk = chunk_t'(rd_bits);

  // Decode items, count ticks and apply chunks read from the store
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    first_d   = first_q;
    ld_slot_d = ld_slot_q;
    ms_d      = ms_q;
    snd_d     = snd_q;
    freq_d    = freq_q;
    lvl_d     = lvl_q;
    type_d    = type_q;
    we        = 1'b0;
    load_req  = 1'b0;
    load_addr = slot_idx;
    done      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_WRITE: begin
              we   = 1'b1;
              done = 1'b1;
            end
            KIND_START: begin
              first_d  = slot_idx;
              load_req = 1'b1;
            end
            KIND_STOP: begin
              snd_d = 1'b0;
              ms_d  = '0;
              done  = 1'b1;
            end
            default: begin
              done = 1'b1;
              if (snd_q && ms_q != '0) begin
                ms_d = ms_q - 1'b1;
                if (ms_q == DUR_W'(1)) begin
                  if (type_q == CT_NORMAL) begin
                    load_req  = 1'b1;
                    load_addr = next_slot;
                    done      = 1'b0;
                  end else if (type_q == CT_REPEAT) begin
                    load_req  = 1'b1;
                    load_addr = first_q;
                    done      = 1'b0;
                  end else begin
                    snd_d = 1'b0;
                  end
                end
              end
            end
          endcase
          if (load_req) begin
            ld_slot_d = load_addr;
            state_d   = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cur_d   = ld_slot_q;
        freq_d  = rd_chunk.freq;
        lvl_d   = rd_chunk.level;
        type_d  = rd_chunk.ctype;
        ms_d    = (rd_chunk.dur == '0) ? DUR_W'(1) : rd_chunk.dur;
        snd_d   = 1'b1;
        done    = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      first_q   <= '0;
      ld_slot_q <= '0;
      ms_q      <= '0;
      snd_q     <= 1'b0;
      freq_q    <= '0;
      lvl_q     <= '0;
      type_q    <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      first_q   <= first_d;
      ld_slot_q <= ld_slot_d;
      ms_q      <= ms_d;
      snd_q     <= snd_d;
      freq_q    <= freq_d;
      lvl_q     <= lvl_d;
      type_q    <= type_d;
    end
  end

  // Chunk store
  tcs_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (CHUNK_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_idx),
    .wdata_i (wr_chunk),
    .raddr_i (load_addr),
    .rdata_o (rd_bits)
  );

  // Build the drive state after the item
  assign res = '{tone_on:    snd_d,
                 tone_freq:  snd_d ? freq_d : '0,
                 tone_level: snd_d ? lvl_d : '0,
                 slot_now:   SLOT_IN_W'(cur_d)};

  tcs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (done),
    .data_i      (res),
    .skid_busy_o (skid_busy),
    .result_o    (result_o)
  );

  // Outside a chunk load the counter runs exactly while a chunk sounds
  a_ms_snd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> snd_q == (ms_q != '0))
    else $error("ms counter out of step with tone");

  // No item is taken while a chunk read is in flight
  a_load_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> !item_i.ready) else $error("item accepted during load");

  // A chunk load always ends sounding and back in idle
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> snd_q && state_q == ST_IDLE)
    else $error("chunk load did not apply");

endmodule
